/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL, included by bdq_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/bdq_pkg.sv */
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int SIZE_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_FIND       = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    // Circular index from a sum that stays below twice the capacity.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
        logic [IDX_W:0] lim;
        lim = (IDX_W + 1)'(CAPACITY);
        if (s >= lim) begin
            wrap_idx = IDX_W'(s - lim);
        end else begin
            wrap_idx = s[IDX_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/bdq_ram.sv */
`timescale 1ns / 1ps

module bdq_ram
    import bdq_pkg::*;
#(
    parameter int DEPTH = CAPACITY,
    parameter int WIDTH = DATA_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bdq_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [DATA_W-1:0]   i_value,
    input  logic [DATA_W-1:0]   i_rdata,
    output t_mem_req            o_mem,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [POS_W-1:0]    o_found_position,
    output logic [SIZE_W-1:0]   o_size
);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_front, n_front;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [DATA_W-1:0]   r_key, n_key;
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_size, n_size;

    logic                full;
    logic                empty;
    logic [IDX_W-1:0]    front_dec;
    logic [IDX_W-1:0]    back_slot;
    logic [CNT_W-1:0]    last_pos;

    assign full      = (r_count == CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);
    assign front_dec = (r_front == '0) ? IDX_W'(CAPACITY - 1) : r_front - 1'b1;
    assign back_slot = wrap_idx({1'b0, r_front} + {1'b0, r_count[IDX_W-1:0]});
    assign last_pos  = r_count - 1'b1;

    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_key    = r_key;
        n_valid  = 1'b0;
        n_status = r_status;
        n_pos    = r_pos;
        n_size   = r_size;
        o_mem.we    = 1'b0;
        o_mem.waddr = back_slot;
        o_mem.wdata = i_value;
        o_mem.raddr = r_front;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_pos    = '0;
                    case (t_op'(i_operation))
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = front_dec;
                                n_front     = front_dec;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem.we = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front = wrap_idx({1'b0, r_front} + (IDX_W + 1)'(1));
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_FIND: begin
                            if (empty) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                // first read issued now, data returns in S_SCAN
                                n_valid = 1'b0;
                                n_key   = i_value;
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_size = n_count;
                end
            end
            S_SCAN: begin
                if (i_rdata == r_key) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_pos    = r_idx;
                    n_size   = r_count;
                    n_state  = S_IDLE;
                end else if (CNT_W'(r_idx) == last_pos) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_pos    = '0;
                    n_size   = r_count;
                    n_state  = S_IDLE;
                end else begin
                    n_idx       = r_idx + 1'b1;
                    o_mem.raddr = wrap_idx({1'b0, r_front} + {1'b0, r_idx}
                                           + (IDX_W + 1)'(1));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_size   <= n_size;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_found_position = POS_W'(r_pos);
    assign o_size           = SIZE_W'(r_size);

    `ASSERT_IMPL(a_scan_nonempty, i_clk, i_rst_n, r_state == S_SCAN, r_count != '0)
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `ASSERT_IMPL(a_empty_size, i_clk, i_rst_n, r_valid && r_status == ST_EMPTY, r_size == '0)
    `ASSERT_IMPL(a_pos_ok, i_clk, i_rst_n, r_valid && r_pos != '0, r_status == ST_OK)
    `ASSERT_NEXT(a_scan_idx, i_clk, i_rst_n, r_state == S_SCAN && n_state == S_SCAN,
                 r_idx == $past(r_idx) + 1'b1)

endmodule

/* hw/rtl/bounded_deque_with_search_top.sv */
`timescale 1ns / 1ps

// Bounded deque of signed 32-bit values with a linear find. Raise start with an
// operation while busy is low; each transaction yields exactly one result,
// shown for a single cycle with o_valid high, and the receiver cannot stall it.
// Pushes, pops and unknown codes leave busy low, so while only these are sent a
// new transaction can be issued every cycle. A find on a non-empty store holds
// busy high while it reads the entry memory one slot per cycle from the front,
// up to the first hit or the last entry; on an empty store it leaves busy low.
// The result appears the cycle after the transaction finishes.

module bounded_deque_with_search_top
    import bdq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           i_operation,
    input  logic signed [DATA_W-1:0]  i_value,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [POS_W-1:0]          o_found_position,
    output logic [SIZE_W-1:0]         o_size
);

    t_mem_req          mem_req;
    logic [DATA_W-1:0] rdata;

    bdq_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .i_rdata          (rdata),
        .o_mem            (mem_req),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_size           (o_size)
    );

    bdq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

endmodule

/* sim/bounded_deque_with_search_top_tb.sv */
`timescale 1ns / 1ps

module bounded_deque_with_search_top_tb;
    import bdq_pkg::*;

    localparam int TOTAL_ITEMS    = 1950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [OP_W-1:0] OP_MID_UNUSED   = 3'd6;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} t_stim_mode;

    typedef struct {
        logic [OP_W-1:0]   op;
        t_status           status;
        logic [POS_W-1:0]  pos;
        logic [SIZE_W-1:0] size;
    } t_deque_result;

    class deque_scoreboard;
        logic signed [DATA_W-1:0] contents[$];
        t_deque_result            pending_q[$];
        int mismatches;
        int checked;
        int n_full;
        int n_empty;
        int n_hit;
        int n_miss;

        function new();
            mismatches = 0;
            checked    = 0;
            n_full     = 0;
            n_empty    = 0;
            n_hit      = 0;
            n_miss     = 0;
        endfunction

        // Apply one accepted transaction to the shadow deque and queue its result.
        function void note(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
            t_deque_result r;
            r.op     = op;
            r.status = ST_OK;
            r.pos    = '0;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (contents.size() >= CAPACITY) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else if (op == OP_PUSH_FRONT) begin
                        contents.push_front(val);
                    end else begin
                        contents.push_back(val);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (contents.size() == 0) begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end else if (op == OP_POP_FRONT) begin
                        void'(contents.pop_front());
                    end else begin
                        void'(contents.pop_back());
                    end
                end
                OP_FIND: begin
                    r.status = ST_NOT_FOUND;
                    for (int i = 0; i < contents.size(); i++) begin
                        if (contents[i] == val) begin
                            r.status = ST_OK;
                            r.pos    = POS_W'(i);
                            break;
                        end
                    end
                    if (r.status == ST_OK) begin
                        n_hit++;
                    end else begin
                        n_miss++;
                    end
                end
                default: ;
            endcase
            r.size = SIZE_W'(contents.size());
            pending_q.push_back(r);
        endfunction

        function void check(logic [1:0] st, logic [POS_W-1:0] pos, logic [SIZE_W-1:0] sz);
            t_deque_result e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result status %0d pos %0d size %0d",
                             $realtime, st, pos, sz);
                end
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (st !== e.status || pos !== e.pos || sz !== e.size) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display({"%0t: mismatch op %0d: expected status %0d pos %0d size %0d,",
                              " got status %0d pos %0d size %0d"},
                             $realtime, e.op, e.status, e.pos, e.size, st, pos, sz);
                end
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          i_operation = OP_PUSH_FRONT;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic [POS_W-1:0]         o_found_position;
    logic [SIZE_W-1:0]        o_size;

    deque_scoreboard          sb;
    int                       idle_pct = 0;
    int                       sent = 0;
    int                       idle_cycles = 0;
    logic signed [DATA_W-1:0] value_pool[8];

    bounded_deque_with_search_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_size           (o_size)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check(o_status, o_found_position, o_size);
            end
            if (start && !busy) begin
                sb.note(i_operation, i_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
                $display("bounded_deque_with_search_top_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(bit for_find);
        int r;
        int n;
        r = $urandom_range(99);
        n = sb.contents.size();
        if (for_find && n > 0 && r < 40) begin
            return sb.contents[$urandom_range(n - 1)];
        end else if (r < 70) begin
            return value_pool[$urandom_range(7)];
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(t_stim_mode mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL: begin
                if (r < 40) return OP_PUSH_FRONT;
                if (r < 80) return OP_PUSH_BACK;
                if (r < 92) return OP_FIND;
                if (r < 96) return OP_POP_FRONT;
                return OP_POP_BACK;
            end
            MODE_DRAIN: begin
                if (r < 35) return OP_POP_FRONT;
                if (r < 70) return OP_POP_BACK;
                if (r < 90) return OP_FIND;
                if (r < 95) return OP_PUSH_FRONT;
                return OP_PUSH_BACK;
            end
            MODE_MIXED: begin
                if (r < 20) return OP_PUSH_FRONT;
                if (r < 40) return OP_PUSH_BACK;
                if (r < 58) return OP_POP_FRONT;
                if (r < 76) return OP_POP_BACK;
                if (r < 96) return OP_FIND;
                return OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
            end
            default: return OP_W'($urandom_range(7));
        endcase
    endfunction

    initial begin
        int            round;
        int            burst;
        t_stim_mode    mode;
        logic [OP_W-1:0] op;

        sb = new();
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sd1;
        for (int i = 5; i < 8; i++) begin
            value_pool[i] = $urandom;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extreme values, each operation, unused codes
        send(OP_FIND,       32'sd0);
        send(OP_POP_FRONT,  32'sd0);
        send(OP_POP_BACK,   32'sd0);
        send(OP_PUSH_BACK,  32'sh7fff_ffff);
        send(OP_PUSH_FRONT, 32'sh8000_0000);
        send(OP_PUSH_BACK,  32'sd0);
        send(OP_PUSH_FRONT, -32'sd1);
        send(OP_FIND,       -32'sd1);
        send(OP_FIND,       32'sd0);
        send(OP_FIND,       32'sh7fff_ffff);
        send(OP_FIND,       32'sd12345);
        send(OP_FIRST_UNUSED, 32'sh5555_5555);
        send(OP_MID_UNUSED, 32'shaaaa_aaaa);
        send(OP_LAST_UNUSED, -32'sd1);
        send(OP_POP_FRONT,  32'sd0);
        send(OP_POP_BACK,   32'sd0);
        send(OP_FIND,       -32'sd1);
        send(OP_PUSH_FRONT, 32'sh5555_5555);
        send(OP_PUSH_BACK,  32'shaaaa_aaaa);
        send(OP_POP_BACK,   32'sd0);
        send(OP_POP_FRONT,  32'sd0);
        send(OP_POP_FRONT,  32'sd0);
        send(OP_POP_FRONT,  32'sd0);
        send(OP_POP_BACK,   32'sd0);
        send(OP_FIND,       32'sh8000_0000);
        wait_drained();

        round = 0;
        while (sent < TOTAL_ITEMS) begin
            case ((round / 2) % 4)
                1:       idle_pct = 55;
                3:       idle_pct = 12;
                default: idle_pct = 0;
            endcase
            case (round % 6)
                0, 1: mode = MODE_FILL;
                2:    mode = MODE_MIXED;
                3, 4: mode = MODE_DRAIN;
                default: mode = MODE_NOISE;
            endcase
            burst = (mode == MODE_NOISE) ? $urandom_range(20, 10) : $urandom_range(120, 40);
            for (int k = 0; k < burst && sent < TOTAL_ITEMS; k++) begin
                op = pick_op(mode);
                send(op, pick_value(op == OP_FIND));
            end
            if (round % 5 == 4) begin
                wait_drained();
            end
            round++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("ran %0d transactions, %0d results checked", sent, sb.checked);
        $display("finds: %0d hits, %0d misses; %0d pushes on full, %0d pops on empty",
                 sb.n_hit, sb.n_miss, sb.n_full, sb.n_empty);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("bounded_deque_with_search_top_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
            $display("bounded_deque_with_search_top_tb: FAIL");
        end
        $finish;
    end

endmodule
